/* design/velocity_accel_kalman_filter_defines.svh */
// Assertion macros used by the checker file of this block.
`ifndef VELOCITY_ACCEL_KALMAN_FILTER_DEFINES_SVH
`define VELOCITY_ACCEL_KALMAN_FILTER_DEFINES_SVH

// Checked property that is switched off while reset is asserted.
`define VAKF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked property that also holds across reset.
`define VAKF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/vakf_pkg.sv */
`timescale 1ns / 1ps

package vakf_pkg;

    localparam int STATE_W   = 48;
    localparam int PROD_W    = 96;
    localparam int Z_W       = 32;
    localparam int DT_W      = 24;
    localparam int OUT_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W    = 4;
    localparam int CNT_W     = 6;
    localparam int MUL_CHUNK = 16;
    localparam int MUL_STEPS = 3;
    localparam int DIV_STEPS = 48;

    localparam logic [CFG_IDX_W-1:0] REG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEASUREMENT_NOISE = 2'd1;

    localparam logic [CFG_W-1:0] PROCESS_NOISE_RST     = 32'd655360;
    localparam logic [CFG_W-1:0] MEASUREMENT_NOISE_RST = 32'd655;

    localparam logic [STATE_W-1:0] MAG48 = 48'h7FFF_FFFF_FFFF;

    // Last step of the predict phase and of the update phase.
    localparam logic [STEP_W-1:0] PREDICT_LAST = 4'd9;
    localparam logic [STEP_W-1:0] UPDATE_LAST  = 4'd14;

    typedef enum logic [2:0] {A_DT, A_Q, A_TA, A_TB, A_P00, A_P01} a_sel_t;
    typedef enum logic [2:0] {B_DT, B_X1, B_P01, B_P11, B_G0, B_E, B_P00} b_sel_t;
    typedef enum logic [1:0] {DIV_FRAC, DIV_HALF_FRAC, DIV_S} div_sel_t;
    typedef enum logic [2:0] {D_G0, D_X0, D_X1, D_P00, D_P01, D_P11, D_TA, D_TB} dst_t;
    typedef enum logic [1:0] {ACC_STORE, ACC_ADD, ACC_SUB} acc_t;

    typedef struct packed {
        a_sel_t   a_sel;
        b_sel_t   b_sel;
        div_sel_t div_sel;
        dst_t     dst;
        acc_t     acc;
    } uop_t;

    typedef struct packed {
        logic       load;
        logic       op_start;
        logic       mul_step;
        logic [1:0] mul_idx;
        logic       round;
        logic       div_step;
        logic       writeback;
        logic       calc_s;
        logic       out_load;
        uop_t       uop;
    } cmd_t;

    typedef struct packed {
        logic lost;
        logic s_positive;
    } status_t;

    // Micro-program: one scaled product and its accumulation per step.
    function automatic uop_t uop_rom(input logic [STEP_W-1:0] idx);
        uop_t u;
        case (idx)
            4'd0:    u = '{A_DT,  B_DT,  DIV_HALF_FRAC, D_G0,  ACC_STORE};
            4'd1:    u = '{A_DT,  B_X1,  DIV_FRAC,      D_X0,  ACC_ADD};
            4'd2:    u = '{A_DT,  B_P01, DIV_FRAC,      D_P00, ACC_ADD};
            4'd3:    u = '{A_DT,  B_P11, DIV_FRAC,      D_P01, ACC_ADD};
            4'd4:    u = '{A_DT,  B_P01, DIV_FRAC,      D_P00, ACC_ADD};
            4'd5:    u = '{A_Q,   B_G0,  DIV_FRAC,      D_TA,  ACC_STORE};
            4'd6:    u = '{A_Q,   B_DT,  DIV_FRAC,      D_TB,  ACC_STORE};
            4'd7:    u = '{A_TA,  B_G0,  DIV_FRAC,      D_P00, ACC_ADD};
            4'd8:    u = '{A_TA,  B_DT,  DIV_FRAC,      D_P01, ACC_ADD};
            4'd9:    u = '{A_TB,  B_DT,  DIV_FRAC,      D_P11, ACC_ADD};
            4'd10:   u = '{A_P00, B_E,   DIV_S,         D_X0,  ACC_ADD};
            4'd11:   u = '{A_P01, B_E,   DIV_S,         D_X1,  ACC_ADD};
            4'd12:   u = '{A_P01, B_P01, DIV_S,         D_P11, ACC_SUB};
            4'd13:   u = '{A_P00, B_P01, DIV_S,         D_P01, ACC_SUB};
            4'd14:   u = '{A_P00, B_P00, DIV_S,         D_P00, ACC_SUB};
            default: u = '{A_DT,  B_DT,  DIV_FRAC,      D_G0,  ACC_STORE};
        endcase
        return u;
    endfunction

    // Saturate a widened sum to the signed 48-bit state range.
    function automatic logic signed [STATE_W-1:0] sat48(input logic signed [STATE_W+1:0] v);
        logic signed [STATE_W+1:0] hi;
        logic signed [STATE_W+1:0] lo;
        hi = 50'sd140737488355327;
        lo = -50'sd140737488355328;
        if (v > hi) begin
            return hi[STATE_W-1:0];
        end else if (v < lo) begin
            return lo[STATE_W-1:0];
        end
        return v[STATE_W-1:0];
    endfunction

    // Saturate a state value to the 32-bit output range.
    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [STATE_W-1:0] v);
        logic signed [STATE_W-1:0] hi;
        logic signed [STATE_W-1:0] lo;
        hi = 48'sd2147483647;
        lo = -48'sd2147483648;
        if (v > hi) begin
            return hi[OUT_W-1:0];
        end else if (v < lo) begin
            return lo[OUT_W-1:0];
        end
        return v[OUT_W-1:0];
    endfunction

endpackage

/* design/velocity_accel_kalman_filter.sv */
`timescale 1ns / 1ps
// Two-state velocity/acceleration Kalman filter with a scalar velocity measurement.
// Input channel (s_*): one transaction per measurement with the measured velocity,
// the elapsed time since the previous measurement and a lost flag.
// Output channel (m_*): one transaction per input with both estimates, saturated
// to 32 bits. Configuration: cfg_write_en writes cfg_data to process noise
// (index 0) or measurement noise (index 1); other indexes are ignored.
// The predict phase runs ten products on the shared 48x16 multiplier, each through
// the operand, multiply, round and write-back states. The update adds the variance
// and decision states plus five scaled products, each also through the 48-step
// restoring divider. A lost item or a nonpositive innovation variance skips the
// update. One item at a time: the next input can be taken from the cycle after the
// result enters the output register.
// Reset clears the state and covariance to zero and loads the default noise values.
// When the receiver stalls, the result holds; a finished second item waits until
// the first is taken.
module velocity_accel_kalman_filter #(
    parameter int DATA_FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [vakf_pkg::Z_W-1:0]       s_measured_velocity,
    input  logic [vakf_pkg::DT_W-1:0]             s_elapsed_time,
    input  logic                                  s_lost,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [vakf_pkg::OUT_W-1:0]     m_velocity_estimate,
    output logic signed [vakf_pkg::OUT_W-1:0]     m_acceleration_estimate,
    input  logic                                  cfg_write_en,
    input  logic [vakf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [vakf_pkg::CFG_W-1:0]            cfg_data
);

    vakf_pkg::cmd_t    cmd;
    vakf_pkg::status_t status;

    vakf_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    vakf_datapath #(
        .DATA_FRAC_BITS (DATA_FRAC_BITS)
    ) u_dp (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .cmd                     (cmd),
        .status                  (status),
        .s_measured_velocity     (s_measured_velocity),
        .s_elapsed_time          (s_elapsed_time),
        .s_lost                  (s_lost),
        .cfg_write_en            (cfg_write_en),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .m_velocity_estimate     (m_velocity_estimate),
        .m_acceleration_estimate (m_acceleration_estimate)
    );

endmodule

/* design/vakf_datapath.sv */
`timescale 1ns / 1ps

module vakf_datapath #(
    parameter int DATA_FRAC_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  vakf_pkg::cmd_t                         cmd,
    output vakf_pkg::status_t                      status,
    input  logic signed [vakf_pkg::Z_W-1:0]        s_measured_velocity,
    input  logic [vakf_pkg::DT_W-1:0]              s_elapsed_time,
    input  logic                                   s_lost,
    input  logic                                   cfg_write_en,
    input  logic [vakf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [vakf_pkg::CFG_W-1:0]             cfg_data,
    output logic signed [vakf_pkg::OUT_W-1:0]      m_velocity_estimate,
    output logic signed [vakf_pkg::OUT_W-1:0]      m_acceleration_estimate
);

    localparam int SW = vakf_pkg::STATE_W;
    localparam int PW = vakf_pkg::PROD_W;
    localparam int MUL_W = SW + vakf_pkg::MUL_CHUNK;
    localparam logic [PW-1:0] HALF_FRAC      = PW'(1) << (DATA_FRAC_BITS - 1);
    localparam logic [PW-1:0] HALF_HALF_FRAC = PW'(1) << DATA_FRAC_BITS;

    logic [vakf_pkg::CFG_W-1:0] q_cfg_reg;
    logic [vakf_pkg::CFG_W-1:0] r_cfg_reg;

    logic signed [SW-1:0] x0_reg, x1_reg, p00_reg, p01_reg, p11_reg;
    logic signed [SW-1:0] g0_reg, ta_reg, tb_reg, s_reg, e_reg;
    logic [vakf_pkg::DT_W-1:0]   dt_reg;
    logic signed [vakf_pkg::Z_W-1:0] z_reg;
    logic                        lost_reg;

    logic [SW-1:0] mag_a_reg, mag_b_reg;
    logic          neg_reg;
    logic [PW-1:0] prod_reg, rem_reg, dsh_reg;
    logic [SW-1:0] q_reg;
    logic signed [vakf_pkg::OUT_W-1:0] vel_out_reg, acc_out_reg;

    logic signed [SW-1:0] dt_ext, op_a, op_b, cur;
    logic [SW-1:0]        mag_res;
    logic [PW-1:0]        shifted, half, partial;
    logic [MUL_W-1:0]     part_prod;
    logic signed [SW+1:0] res, acc_val;
    logic                 ge;

    assign dt_ext = $signed({{(SW - vakf_pkg::DT_W){1'b0}}, dt_reg});

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cfg_reg <= vakf_pkg::PROCESS_NOISE_RST;
            r_cfg_reg <= vakf_pkg::MEASUREMENT_NOISE_RST;
        end else if (cfg_write_en) begin
            if (cfg_index == vakf_pkg::REG_PROCESS_NOISE) begin
                q_cfg_reg <= cfg_data;
            end else if (cfg_index == vakf_pkg::REG_MEASUREMENT_NOISE) begin
                r_cfg_reg <= cfg_data;
            end
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        unique case (cmd.uop.a_sel)
            vakf_pkg::A_Q:   op_a = $signed({{(SW - vakf_pkg::CFG_W){1'b0}}, q_cfg_reg});
            vakf_pkg::A_TA:  op_a = ta_reg;
            vakf_pkg::A_TB:  op_a = tb_reg;
            vakf_pkg::A_P00: op_a = p00_reg;
            vakf_pkg::A_P01: op_a = p01_reg;
            default:         op_a = dt_ext;
        endcase
        unique case (cmd.uop.b_sel)
            vakf_pkg::B_X1:  op_b = x1_reg;
            vakf_pkg::B_P01: op_b = p01_reg;
            vakf_pkg::B_P11: op_b = p11_reg;
            vakf_pkg::B_G0:  op_b = g0_reg;
            vakf_pkg::B_E:   op_b = e_reg;
            vakf_pkg::B_P00: op_b = p00_reg;
            default:         op_b = dt_ext;
        endcase
    end

    // One 48 by 16 partial product per multiply cycle.
    always_comb begin
        part_prod = MUL_W'(mag_a_reg)
                    * MUL_W'(mag_b_reg[cmd.mul_idx * vakf_pkg::MUL_CHUNK +: vakf_pkg::MUL_CHUNK]);
        partial   = PW'(part_prod) << (cmd.mul_idx * vakf_pkg::MUL_CHUNK);
    end

    // Rounding offset is half of the divisor.
    always_comb begin
        unique case (cmd.uop.div_sel)
            vakf_pkg::DIV_HALF_FRAC: half = HALF_HALF_FRAC;
            vakf_pkg::DIV_S:         half = {{(PW - SW + 1){1'b0}}, s_reg[SW-1:1]};
            default:                 half = HALF_FRAC;
        endcase
    end

    assign ge = rem_reg >= dsh_reg;

    // Scaled magnitude, sign restore and accumulation into the destination.
    always_comb begin
        if (cmd.uop.div_sel == vakf_pkg::DIV_HALF_FRAC) begin
            shifted = rem_reg >> (DATA_FRAC_BITS + 1);
        end else begin
            shifted = rem_reg >> DATA_FRAC_BITS;
        end
        if (cmd.uop.div_sel == vakf_pkg::DIV_S) begin
            mag_res = q_reg[SW-1] ? vakf_pkg::MAG48 : q_reg;
        end else begin
            mag_res = (|shifted[PW-1:SW-1]) ? vakf_pkg::MAG48 : shifted[SW-1:0];
        end
        res = neg_reg ? -$signed({2'b00, mag_res}) : $signed({2'b00, mag_res});
        unique case (cmd.uop.dst)
            vakf_pkg::D_X0:  cur = x0_reg;
            vakf_pkg::D_X1:  cur = x1_reg;
            vakf_pkg::D_P00: cur = p00_reg;
            vakf_pkg::D_P01: cur = p01_reg;
            vakf_pkg::D_P11: cur = p11_reg;
            vakf_pkg::D_TA:  cur = ta_reg;
            vakf_pkg::D_TB:  cur = tb_reg;
            default:         cur = g0_reg;
        endcase
        unique case (cmd.uop.acc)
            vakf_pkg::ACC_ADD: acc_val = $signed({{2{cur[SW-1]}}, cur}) + res;
            vakf_pkg::ACC_SUB: acc_val = $signed({{2{cur[SW-1]}}, cur}) - res;
            default:           acc_val = res;
        endcase
    end

    // Multiply, round and divide registers.
    always_ff @(posedge aclk) begin
        if (cmd.op_start) begin
            mag_a_reg <= op_a[SW-1] ? SW'(-op_a) : op_a;
            mag_b_reg <= op_b[SW-1] ? SW'(-op_b) : op_b;
            neg_reg   <= op_a[SW-1] ^ op_b[SW-1];
            prod_reg  <= '0;
        end else if (cmd.mul_step) begin
            prod_reg <= prod_reg + partial;
        end
        if (cmd.round) begin
            rem_reg <= prod_reg + half;
            dsh_reg <= {2'b00, s_reg[SW-2:0], {(SW - 1){1'b0}}};
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[SW-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    // Item capture.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dt_reg   <= s_elapsed_time;
            z_reg    <= s_measured_velocity;
            lost_reg <= s_lost;
        end
    end

    // Filter state and scratch values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x0_reg  <= '0;
            x1_reg  <= '0;
            p00_reg <= '0;
            p01_reg <= '0;
            p11_reg <= '0;
        end else if (cmd.writeback) begin
            unique case (cmd.uop.dst)
                vakf_pkg::D_X0:  x0_reg  <= vakf_pkg::sat48(acc_val);
                vakf_pkg::D_X1:  x1_reg  <= vakf_pkg::sat48(acc_val);
                vakf_pkg::D_P00: p00_reg <= vakf_pkg::sat48(acc_val);
                vakf_pkg::D_P01: p01_reg <= vakf_pkg::sat48(acc_val);
                vakf_pkg::D_P11: p11_reg <= vakf_pkg::sat48(acc_val);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.writeback) begin
            unique case (cmd.uop.dst)
                vakf_pkg::D_G0: g0_reg <= vakf_pkg::sat48(acc_val);
                vakf_pkg::D_TA: ta_reg <= vakf_pkg::sat48(acc_val);
                vakf_pkg::D_TB: tb_reg <= vakf_pkg::sat48(acc_val);
                default: ;
            endcase
        end
        if (cmd.calc_s) begin
            s_reg <= vakf_pkg::sat48($signed({{2{p00_reg[SW-1]}}, p00_reg})
                     + $signed({{(SW + 2 - vakf_pkg::CFG_W){1'b0}}, r_cfg_reg}));
            e_reg <= vakf_pkg::sat48($signed({{(SW + 2 - vakf_pkg::Z_W){z_reg[vakf_pkg::Z_W-1]}},
                     z_reg}) - $signed({{2{x0_reg[SW-1]}}, x0_reg}));
        end
        if (cmd.out_load) begin
            vel_out_reg <= vakf_pkg::sat32(x0_reg);
            acc_out_reg <= vakf_pkg::sat32(x1_reg);
        end
    end

    assign status.lost       = lost_reg;
    assign status.s_positive = !s_reg[SW-1] && (|s_reg);

    assign m_velocity_estimate     = vel_out_reg;
    assign m_acceleration_estimate = acc_out_reg;

endmodule

/* design/vakf_controller.sv */
`timescale 1ns / 1ps

module vakf_controller (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  vakf_pkg::status_t status,
    output vakf_pkg::cmd_t    cmd
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_OPER  = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_ROUND = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_WB    = 4'd5;
    localparam logic [3:0] ST_SCALC = 4'd6;
    localparam logic [3:0] ST_SDEC  = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]                    state_reg, state_next;
    logic [vakf_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [vakf_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          m_valid_reg, m_valid_next;
    vakf_pkg::uop_t                uop;

    assign uop = vakf_pkg::uop_rom(step_reg);

    // Sequencer: one micro-step of multiply, round, optional divide and write-back.
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.uop      = uop;
        cmd.mul_idx  = cnt_reg[1:0];
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = ST_OPER;
                end
            end
            ST_OPER: begin
                cmd.op_start = 1'b1;
                cnt_next     = '0;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == vakf_pkg::CNT_W'(vakf_pkg::MUL_STEPS - 1)) begin
                    state_next = ST_ROUND;
                end else begin
                    cnt_next = cnt_reg + vakf_pkg::CNT_W'(1);
                end
            end
            ST_ROUND: begin
                cmd.round = 1'b1;
                cnt_next  = '0;
                if (uop.div_sel == vakf_pkg::DIV_S) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == vakf_pkg::CNT_W'(vakf_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_WB;
                end else begin
                    cnt_next = cnt_reg + vakf_pkg::CNT_W'(1);
                end
            end
            ST_WB: begin
                cmd.writeback = 1'b1;
                if (step_reg == vakf_pkg::PREDICT_LAST) begin
                    state_next = ST_SCALC;
                end else if (step_reg == vakf_pkg::UPDATE_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    step_next  = step_reg + vakf_pkg::STEP_W'(1);
                    state_next = ST_OPER;
                end
            end
            ST_SCALC: begin
                cmd.calc_s = 1'b1;
                state_next = ST_SDEC;
            end
            ST_SDEC: begin
                if (status.lost || !status.s_positive) begin
                    state_next = ST_DONE;
                end else begin
                    step_next  = step_reg + vakf_pkg::STEP_W'(1);
                    state_next = ST_OPER;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register valid flag.
    always_comb begin
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

/* design/vakf_checker.sv */
`timescale 1ns / 1ps
`include "velocity_accel_kalman_filter_defines.svh"

module vakf_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [vakf_pkg::OUT_W-1:0] m_velocity_estimate
);

    // A stalled result stays offered.
    `VAKF_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "result dropped while stalled")

    // A stalled result keeps its value.
    `VAKF_ASSERT(a_out_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_velocity_estimate), "result changed while stalled")

    // The filter works on one item at a time, so it is busy right after an accept.
    `VAKF_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input taken while busy")

    // Reset leaves no result offered.
    `VAKF_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind velocity_accel_kalman_filter vakf_checker u_vakf_checker (
    .aclk                (aclk),
    .aresetn             (aresetn),
    .s_valid             (s_valid),
    .s_ready             (s_ready),
    .m_valid             (m_valid),
    .m_ready             (m_ready),
    .m_velocity_estimate (m_velocity_estimate)
);
